// ===== hw/rtl/smstep_pkg.sv =====
// ----------------------------------------------------------------------------
// smstep_pkg
// Shared constants, opcode and status codes, state and control types for the
// stack machine step engine.
// ----------------------------------------------------------------------------
package smstep_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = SP_W + 1;
	localparam int CALL_DEPTH  = 64;
	localparam int CP_W        = $clog2(CALL_DEPTH);
	localparam int CDEPTH_W    = CP_W + 1;
	localparam int PROG_DEPTH  = 1024;
	localparam int PA_W        = $clog2(PROG_DEPTH);
	localparam int PLEN_W      = 11;
	localparam int OP_W        = 5;
	localparam int WORD_W      = 64;
	localparam int ST_W        = 3;

	typedef enum logic [OP_W-1:0] {
		OP_NOP   = 5'd0,
		OP_HALT  = 5'd1,
		OP_PUSH  = 5'd2,
		OP_POP   = 5'd3,
		OP_COPY  = 5'd4,
		OP_SWAP  = 5'd5,
		OP_ADD_I = 5'd6,
		OP_SUB_I = 5'd7,
		OP_MUL_I = 5'd8,
		OP_DIV_I = 5'd9,
		OP_ADD_U = 5'd10,
		OP_SUB_U = 5'd11,
		OP_MUL_U = 5'd12,
		OP_DIV_U = 5'd13,
		OP_EQ    = 5'd14,
		OP_NE    = 5'd15,
		OP_GT_I  = 5'd16,
		OP_GE_I  = 5'd17,
		OP_LT_I  = 5'd18,
		OP_LE_I  = 5'd19,
		OP_GT_U  = 5'd20,
		OP_GE_U  = 5'd21,
		OP_LT_U  = 5'd22,
		OP_LE_U  = 5'd23,
		OP_JMP   = 5'd24,
		OP_JNZ   = 5'd25,
		OP_CALL  = 5'd26,
		OP_RET   = 5'd27
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_IPOVF   = 3'd1,
		ST_OVER    = 3'd2,
		ST_UNDER   = 3'd3,
		ST_COVER   = 3'd4,
		ST_CUNDER  = 3'd5,
		ST_ILLEGAL = 3'd6,
		ST_DIVZERO = 3'd7
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_DECODE,
		S_EXEC,
		S_MD,
		S_WR2,
		S_TOP,
		S_TOPL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic fetch;
		logic decode;
		logic exec;
		logic md_start;
		logic md_commit;
		logic wr2;
		logic stk_rd;
		logic top_latch;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_step;
		logic ip_fault;
		logic chk_err;
		logic md_op;
		logic div_zero;
		logic is_swap;
		logic md_done;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hw/rtl/smstep_muldiv.sv =====
// ----------------------------------------------------------------------------
// smstep_muldiv
// Bit-serial 64-bit multiplier (low product) and restoring divider, one bit
// per cycle, signed division through magnitudes.
// ----------------------------------------------------------------------------
module smstep_muldiv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            is_div,
	input  logic                            is_signed,
	input  logic [smstep_pkg::WORD_W-1:0]   a,
	input  logic [smstep_pkg::WORD_W-1:0]   b,
	output logic                            done,
	output logic [smstep_pkg::WORD_W-1:0]   result
);

	localparam int W = smstep_pkg::WORD_W;

	logic                 busy_q;
	logic                 done_q;
	logic [$clog2(W)-1:0] cnt_q;
	logic                 div_q;
	logic                 neg_q;
	logic [W:0]           rem_q;
	logic [W-1:0]         x_q;
	logic [W-1:0]         y_q;

	logic [W-1:0] ma;
	logic [W-1:0] mb;
	logic [W:0]   r2;
	logic         ge;

	assign ma = (is_signed && a[W-1]) ? (~a + W'(1)) : a;
	assign mb = (is_signed && b[W-1]) ? (~b + W'(1)) : b;
	assign r2 = {rem_q[W-1:0], x_q[W-1]};
	assign ge = r2 >= {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= is_div && is_signed && (a[W-1] ^ b[W-1]);
			rem_q <= '0;
			x_q   <= is_div ? ma : a;
			y_q   <= is_div ? mb : b;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= ge ? (r2 - {1'b0, y_q}) : r2;
				x_q   <= {x_q[W-2:0], ge};
			end else begin
				// shift-add, only the low word of the product is kept
				if (y_q[0])
					rem_q <= {1'b0, rem_q[W-1:0] + x_q};
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? (neg_q ? (~x_q + W'(1)) : x_q) : rem_q[W-1:0];

endmodule

// ===== hw/rtl/smstep_dp.sv =====
// ----------------------------------------------------------------------------
// smstep_dp
// Datapath: program store, data and return stacks, machine registers, alu,
// multiply/divide unit and the result register.
// ----------------------------------------------------------------------------
module smstep_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smstep_pkg::ctrl_cmd_t                 ctl,
	output smstep_pkg::dp_sts_t                   sts,
	input  logic                                 cfg_we,
	input  logic [smstep_pkg::PLEN_W-1:0]        cfg_wdata,
	input  logic                                 cmd,
	input  logic [smstep_pkg::PA_W-1:0]          load_address,
	input  logic [smstep_pkg::OP_W-1:0]          load_opcode,
	input  logic [smstep_pkg::WORD_W-1:0]        load_operand,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [smstep_pkg::ST_W-1:0]          status,
	output logic                                 halted,
	output logic [smstep_pkg::WORD_W-1:0]        next_ip,
	output logic [smstep_pkg::DEPTH_W-1:0]       stack_count,
	output logic [smstep_pkg::WORD_W-1:0]        top_value,
	output logic [smstep_pkg::CDEPTH_W-1:0]      call_count
);

	localparam int W   = smstep_pkg::WORD_W;
	localparam int SPW = smstep_pkg::SP_W;
	localparam int DW  = smstep_pkg::DEPTH_W;
	localparam int CPW = smstep_pkg::CP_W;
	localparam int CDW = smstep_pkg::CDEPTH_W;
	localparam int PW  = smstep_pkg::PA_W;
	localparam int LW  = smstep_pkg::PLEN_W;
	localparam int OW  = smstep_pkg::OP_W;

	// memories
	logic [OW+W-1:0] prog_mem [smstep_pkg::PROG_DEPTH];
	logic [W-1:0]    dstk_mem [smstep_pkg::STACK_DEPTH];
	logic [W-1:0]    rstk_mem [smstep_pkg::CALL_DEPTH];

	// machine state
	logic [LW-1:0]           plen_q;
	logic [W-1:0]            ip_q;
	logic [DW-1:0]           depth_q;
	logic [CDW-1:0]          rdepth_q;
	logic                    halt_q;
	smstep_pkg::stat_t       st_q;
	logic [OW+W-1:0]         prog_rd_q;
	logic [OW-1:0]           ir_op_q;
	logic [W-1:0]            ir_arg_q;
	logic [W-1:0]            rda_q;
	logic [W-1:0]            rdb_q;
	logic [W-1:0]            rret_q;
	logic [W-1:0]            top_q;
	logic                    out_valid_q;

	logic [ smstep_pkg::ST_W-1:0] out_status_q;
	logic                         out_halted_q;
	logic [W-1:0]                 out_ip_q;
	logic [DW-1:0]                out_count_q;
	logic [W-1:0]                 out_top_q;
	logic [CDW-1:0]               out_call_q;

	logic [LW-1:0]     limit;
	logic              ip_fault;
	smstep_pkg::op_t   op;
	logic              full;
	logic              arg_big;
	logic              dep_lt_arg;
	logic              dep_le_arg;
	logic [SPW-1:0]    k8;
	logic [SPW-1:0]    addr_a;
	logic [SPW-1:0]    addr_b;
	logic [CPW-1:0]    raddr;
	smstep_pkg::stat_t chk;
	logic              is_bin;
	logic              md_op;
	logic              is_divop;
	logic              div_zero;
	logic [W-1:0]      alu;
	logic              md_done;
	logic [W-1:0]      md_res;

	logic              dwr_en;
	logic [SPW-1:0]    dwr_addr;
	logic [W-1:0]      dwr_data;

	assign limit    = (plen_q > LW'(smstep_pkg::PROG_DEPTH)) ? LW'(smstep_pkg::PROG_DEPTH)
	                                                          : plen_q;
	assign ip_fault = ip_q >= W'(limit);

	assign op         = smstep_pkg::op_t'(ir_op_q);
	assign full       = depth_q >= DW'(smstep_pkg::STACK_DEPTH);
	assign arg_big    = |ir_arg_q[W-1:DW];
	assign dep_lt_arg = arg_big || (depth_q < ir_arg_q[DW-1:0]);
	assign dep_le_arg = arg_big || (depth_q <= ir_arg_q[DW-1:0]);
	assign k8         = ir_arg_q[SPW-1:0];
	assign addr_b     = depth_q[SPW-1:0] - SPW'(1);
	assign raddr      = rdepth_q[CPW-1:0] - CPW'(1);

	always_comb begin
		unique case (op)
			smstep_pkg::OP_COPY: addr_a = depth_q[SPW-1:0] - k8;
			smstep_pkg::OP_SWAP: addr_a = depth_q[SPW-1:0] - SPW'(1) - k8;
			default:             addr_a = depth_q[SPW-1:0] - SPW'(2);
		endcase
	end

	always_comb begin
		is_bin   = (ir_op_q >= OW'(smstep_pkg::OP_ADD_I)) && (ir_op_q <= OW'(smstep_pkg::OP_LE_U));
		md_op    = (op == smstep_pkg::OP_MUL_I) || (op == smstep_pkg::OP_MUL_U) ||
		           (op == smstep_pkg::OP_DIV_I) || (op == smstep_pkg::OP_DIV_U);
		is_divop = (op == smstep_pkg::OP_DIV_I) || (op == smstep_pkg::OP_DIV_U);
		div_zero = is_divop && (rdb_q == '0);
	end

	// bounds checks ahead of any stack write
	always_comb begin
		chk = smstep_pkg::ST_OK;
		if (is_bin) begin
			if (depth_q < DW'(2))
				chk = smstep_pkg::ST_UNDER;
		end else begin
			case (op)
				smstep_pkg::OP_NOP, smstep_pkg::OP_HALT, smstep_pkg::OP_JMP: chk = smstep_pkg::ST_OK;
				smstep_pkg::OP_PUSH: if (full) chk = smstep_pkg::ST_OVER;
				smstep_pkg::OP_POP, smstep_pkg::OP_JNZ:
					if (depth_q == '0) chk = smstep_pkg::ST_UNDER;
				smstep_pkg::OP_COPY: begin
					if (full)
						chk = smstep_pkg::ST_OVER;
					else if (dep_lt_arg)
						chk = smstep_pkg::ST_UNDER;
					else if (ir_arg_q == '0)
						chk = smstep_pkg::ST_OVER;
				end
				smstep_pkg::OP_SWAP: begin
					if (dep_le_arg)
						chk = smstep_pkg::ST_UNDER;
					else if (ir_arg_q == '0)
						chk = smstep_pkg::ST_OVER;
				end
				smstep_pkg::OP_CALL:
					if (rdepth_q >= CDW'(smstep_pkg::CALL_DEPTH)) chk = smstep_pkg::ST_COVER;
				smstep_pkg::OP_RET: if (rdepth_q == '0) chk = smstep_pkg::ST_CUNDER;
				default: chk = smstep_pkg::ST_ILLEGAL;
			endcase
		end
	end

	// a = second entry, b = top entry
	always_comb begin
		case (op)
			smstep_pkg::OP_ADD_I, smstep_pkg::OP_ADD_U: alu = rda_q + rdb_q;
			smstep_pkg::OP_SUB_I, smstep_pkg::OP_SUB_U: alu = rda_q - rdb_q;
			smstep_pkg::OP_EQ:   alu = W'(rda_q == rdb_q);
			smstep_pkg::OP_NE:   alu = W'(rda_q != rdb_q);
			smstep_pkg::OP_GT_I: alu = W'($signed(rda_q) >  $signed(rdb_q));
			smstep_pkg::OP_GE_I: alu = W'($signed(rda_q) >= $signed(rdb_q));
			smstep_pkg::OP_LT_I: alu = W'($signed(rda_q) <  $signed(rdb_q));
			smstep_pkg::OP_LE_I: alu = W'($signed(rda_q) <= $signed(rdb_q));
			smstep_pkg::OP_GT_U: alu = W'(rda_q >  rdb_q);
			smstep_pkg::OP_GE_U: alu = W'(rda_q >= rdb_q);
			smstep_pkg::OP_LT_U: alu = W'(rda_q <  rdb_q);
			default:             alu = W'(rda_q <= rdb_q);
		endcase
	end

	smstep_muldiv u_muldiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.md_start),
		.is_div    (is_divop),
		.is_signed ((op == smstep_pkg::OP_MUL_I) || (op == smstep_pkg::OP_DIV_I)),
		.a         (rda_q),
		.b         (rdb_q),
		.done      (md_done),
		.result    (md_res)
	);

	// data stack write port
	always_comb begin
		dwr_en   = 1'b0;
		dwr_addr = addr_a;
		dwr_data = alu;
		if (ctl.md_commit) begin
			dwr_en   = 1'b1;
			dwr_data = md_res;
		end else if (ctl.wr2) begin
			dwr_en   = 1'b1;
			dwr_addr = addr_b;
			dwr_data = rda_q;
		end else if (ctl.exec && !md_op) begin
			if (is_bin) begin
				dwr_en = 1'b1;
			end else begin
				case (op)
					smstep_pkg::OP_PUSH: begin
						dwr_en   = 1'b1;
						dwr_addr = depth_q[SPW-1:0];
						dwr_data = ir_arg_q;
					end
					smstep_pkg::OP_COPY: begin
						dwr_en   = 1'b1;
						dwr_addr = depth_q[SPW-1:0];
						dwr_data = rda_q;
					end
					smstep_pkg::OP_SWAP: begin
						dwr_en   = 1'b1;
						dwr_data = rdb_q;
					end
					default: dwr_en = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && !cmd)
			prog_mem[load_address] <= {load_opcode, load_operand};
		if (ctl.accept)
			prog_rd_q <= prog_mem[ip_q[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dwr_en)
			dstk_mem[dwr_addr] <= dwr_data;
		if (ctl.stk_rd) begin
			rda_q <= dstk_mem[addr_a];
			rdb_q <= dstk_mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && (op == smstep_pkg::OP_CALL))
			rstk_mem[rdepth_q[CPW-1:0]] <= ip_q;
		if (ctl.stk_rd)
			rret_q <= rstk_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.fetch) begin
			ir_op_q  <= prog_rd_q[OW+W-1:W];
			ir_arg_q <= prog_rd_q[W-1:0];
		end
		if (ctl.top_latch)
			top_q <= rdb_q;
		if (ctl.out_load) begin
			out_status_q <= st_q;
			out_halted_q <= halt_q;
			out_ip_q     <= ip_q;
			out_count_q  <= depth_q;
			out_top_q    <= (depth_q == '0) ? '0 : top_q;
			out_call_q   <= rdepth_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q      <= '0;
			ip_q        <= '0;
			depth_q     <= '0;
			rdepth_q    <= '0;
			halt_q      <= 1'b0;
			st_q        <= smstep_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				plen_q <= cfg_wdata;
			if (ctl.accept)
				st_q <= (cmd && ip_fault) ? smstep_pkg::ST_IPOVF : smstep_pkg::ST_OK;
			if (ctl.fetch)
				ip_q <= ip_q + W'(1);
			if (ctl.decode)
				st_q <= chk;
			if (ctl.exec && div_zero)
				st_q <= smstep_pkg::ST_DIVZERO;
			if (ctl.md_commit)
				depth_q <= depth_q - DW'(1);
			if (ctl.exec && !md_op) begin
				if (is_bin) begin
					depth_q <= depth_q - DW'(1);
				end else begin
					case (op)
						smstep_pkg::OP_HALT: halt_q <= 1'b1;
						smstep_pkg::OP_PUSH, smstep_pkg::OP_COPY: depth_q <= depth_q + DW'(1);
						smstep_pkg::OP_POP: depth_q <= depth_q - DW'(1);
						smstep_pkg::OP_JMP: ip_q <= ir_arg_q;
						smstep_pkg::OP_JNZ: begin
							if (rdb_q != '0)
								ip_q <= ir_arg_q;
							depth_q <= depth_q - DW'(1);
						end
						smstep_pkg::OP_CALL: begin
							ip_q     <= ir_arg_q;
							rdepth_q <= rdepth_q + CDW'(1);
						end
						smstep_pkg::OP_RET: begin
							ip_q     <= rret_q;
							rdepth_q <= rdepth_q - CDW'(1);
						end
						default: halt_q <= halt_q;
					endcase
				end
			end
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.is_step  = cmd;
		sts.ip_fault = ip_fault;
		sts.chk_err  = chk != smstep_pkg::ST_OK;
		sts.md_op    = md_op;
		sts.div_zero = div_zero;
		sts.is_swap  = op == smstep_pkg::OP_SWAP;
		sts.md_done  = md_done;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign halted      = out_halted_q;
	assign next_ip     = out_ip_q;
	assign stack_count = out_count_q;
	assign top_value   = out_top_q;
	assign call_count  = out_call_q;

endmodule

// ===== hw/rtl/smstep_ctrl.sv =====
// ----------------------------------------------------------------------------
// smstep_ctrl
// Controller: sequences fetch, decode, execute, multiply/divide wait, second
// swap write, top-of-stack refresh and result hand-off.
// ----------------------------------------------------------------------------
module smstep_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  smstep_pkg::dp_sts_t   sts,
	output smstep_pkg::ctrl_cmd_t ctl
);

	smstep_pkg::state_t state_q;
	smstep_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= smstep_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smstep_pkg::S_IDLE:
				if (in_valid)
					state_d = (sts.is_step && !sts.ip_fault) ? smstep_pkg::S_FETCH
					                                          : smstep_pkg::S_DONE;
			smstep_pkg::S_FETCH:  state_d = smstep_pkg::S_DECODE;
			smstep_pkg::S_DECODE: state_d = sts.chk_err ? smstep_pkg::S_DONE : smstep_pkg::S_EXEC;
			smstep_pkg::S_EXEC: begin
				if (sts.div_zero)
					state_d = smstep_pkg::S_DONE;
				else if (sts.md_op)
					state_d = smstep_pkg::S_MD;
				else if (sts.is_swap)
					state_d = smstep_pkg::S_WR2;
				else
					state_d = smstep_pkg::S_TOP;
			end
			smstep_pkg::S_MD:   if (sts.md_done) state_d = smstep_pkg::S_TOP;
			smstep_pkg::S_WR2:  state_d = smstep_pkg::S_TOP;
			smstep_pkg::S_TOP:  state_d = smstep_pkg::S_TOPL;
			smstep_pkg::S_TOPL: state_d = smstep_pkg::S_DONE;
			smstep_pkg::S_DONE: if (sts.out_free) state_d = smstep_pkg::S_IDLE;
			default:            state_d = smstep_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			smstep_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
			end
			smstep_pkg::S_FETCH: ctl.fetch = 1'b1;
			smstep_pkg::S_DECODE: begin
				ctl.decode = 1'b1;
				ctl.stk_rd = 1'b1;
			end
			smstep_pkg::S_EXEC: begin
				ctl.exec     = 1'b1;
				ctl.md_start = sts.md_op && !sts.div_zero;
			end
			smstep_pkg::S_MD:   ctl.md_commit = sts.md_done;
			smstep_pkg::S_WR2:  ctl.wr2 = 1'b1;
			smstep_pkg::S_TOP:  ctl.stk_rd = 1'b1;
			smstep_pkg::S_TOPL: ctl.top_latch = 1'b1;
			smstep_pkg::S_DONE: ctl.out_load = sts.out_free;
			default:            ctl = '0;
		endcase
	end

endmodule

// ===== hw/rtl/stack_machine_step.sv =====
// ----------------------------------------------------------------------------
// stack_machine_step
// A step item passes fetch, decode, execute, swap write or multiply/divide wait
// and top-of-stack refresh; a load item skips these. One item at a time.
// Throughput is set by the single-write data stack memory and the serial
// multiply/divide loop. An output register lets the result wait for the sink.
// Reset clears the pointers, depths, halt flag and length register; program
// store and both stacks are undefined until written.
// ----------------------------------------------------------------------------
module stack_machine_step (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [smstep_pkg::PLEN_W-1:0]      cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [smstep_pkg::PA_W-1:0]        load_address,
	input  logic [smstep_pkg::OP_W-1:0]        load_opcode,
	input  logic [smstep_pkg::WORD_W-1:0]      load_operand,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [smstep_pkg::ST_W-1:0]        status,
	output logic                               halted,
	output logic [smstep_pkg::WORD_W-1:0]      next_ip,
	output logic [smstep_pkg::DEPTH_W-1:0]     stack_count,
	output logic [smstep_pkg::WORD_W-1:0]      top_value,
	output logic [smstep_pkg::CDEPTH_W-1:0]    call_count
);

	smstep_pkg::ctrl_cmd_t ctl;
	smstep_pkg::dp_sts_t   sts;

	smstep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	smstep_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.load_address (load_address),
		.load_opcode  (load_opcode),
		.load_operand (load_operand),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.halted       (halted),
		.next_ip      (next_ip),
		.stack_count  (stack_count),
		.top_value    (top_value),
		.call_count   (call_count)
	);

endmodule

// ===== tb/stack_machine_step_tb.sv =====
// ----------------------------------------------------------------------------
// stack_machine_step_tb
// Self-checking bench for the stack machine step engine. Every accepted item
// is run through a local model of the machine. Each result from the block is
// checked field by field against the oldest predicted result. Directed tests
// cover faults, every operation and the stack limits. Random programs are then
// built word by word just ahead of the instruction pointer.
// ----------------------------------------------------------------------------
module stack_machine_step_tb;

	localparam int          ST_W        = smstep_pkg::ST_W;
	localparam int          WORD_W      = smstep_pkg::WORD_W;
	localparam int          DEPTH_W     = smstep_pkg::DEPTH_W;
	localparam int          CDEPTH_W    = smstep_pkg::CDEPTH_W;
	localparam int          PLEN_W      = smstep_pkg::PLEN_W;
	localparam int          PA_W        = smstep_pkg::PA_W;
	localparam int          OP_W        = smstep_pkg::OP_W;
	localparam int          PROG_DEPTH  = smstep_pkg::PROG_DEPTH;
	localparam int          STACK_DEPTH = smstep_pkg::STACK_DEPTH;
	localparam int          CALL_DEPTH  = smstep_pkg::CALL_DEPTH;

	localparam logic        CMD_LOAD  = 1'b0;
	localparam logic        CMD_STEP  = 1'b1;
	localparam logic [4:0]  OP_BAD_LO = 5'd28;
	localparam logic [4:0]  OP_BAD_HI = 5'd31;
	localparam logic [63:0] MIN_INT   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_INT   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int          CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [ST_W-1:0]     status;
		logic                halted;
		logic [WORD_W-1:0]   ip;
		logic [DEPTH_W-1:0]  count;
		logic [WORD_W-1:0]   top;
		logic [CDEPTH_W-1:0] calls;
	} machine_view_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [PLEN_W-1:0]   cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic                cmd;
	logic [PA_W-1:0]     load_address;
	logic [OP_W-1:0]     load_opcode;
	logic [WORD_W-1:0]   load_operand;
	logic                out_valid;
	logic                out_ready;
	logic [ST_W-1:0]     status;
	logic                halted;
	logic [WORD_W-1:0]   next_ip;
	logic [DEPTH_W-1:0]  stack_count;
	logic [WORD_W-1:0]   top_value;
	logic [CDEPTH_W-1:0] call_count;

	// local copy of the machine
	logic [OP_W-1:0]   prog_op  [PROG_DEPTH];
	logic [WORD_W-1:0] prog_arg [PROG_DEPTH];
	bit                written  [PROG_DEPTH];
	logic [WORD_W-1:0] data_mem [STACK_DEPTH];
	logic [WORD_W-1:0] ret_mem  [CALL_DEPTH];
	int                depth;
	int                rdepth;
	logic [WORD_W-1:0] ip;
	logic              halt_flag;
	logic [PLEN_W-1:0] plen;

	machine_view_t pending_views[$];
	int  err_count;
	int  cycles;
	int  hold_cycles;
	bit  no_idle;
	int  n_loads;
	int  n_steps;
	int  n_faults;

	stack_machine_step i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.load_address (load_address),
		.load_opcode  (load_opcode),
		.load_operand (load_operand),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.halted       (halted),
		.next_ip      (next_ip),
		.stack_count  (stack_count),
		.top_value    (top_value),
		.call_count   (call_count)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int fetch_limit();
		return (plen < PROG_DEPTH) ? int'(plen) : PROG_DEPTH;
	endfunction

	function automatic logic [63:0] signed_quotient(logic [63:0] a, logic [63:0] b);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q  = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic smstep_pkg::stat_t execute_word();
		logic [OP_W-1:0] o;
		logic [63:0]     arg;
		logic [63:0]     a;
		logic [63:0]     b;
		logic [63:0]     r;
		logic [63:0]     t;
		int              k;
		if (ip >= 64'(fetch_limit()))
			return smstep_pkg::ST_IPOVF;
		o   = prog_op[ip[PA_W-1:0]];
		arg = prog_arg[ip[PA_W-1:0]];
		ip  = ip + 1;
		case (o)
			smstep_pkg::OP_NOP: return smstep_pkg::ST_OK;
			smstep_pkg::OP_HALT: begin
				halt_flag = 1'b1;
				return smstep_pkg::ST_OK;
			end
			smstep_pkg::OP_PUSH: begin
				if (depth >= STACK_DEPTH) return smstep_pkg::ST_OVER;
				data_mem[depth] = arg;
				depth++;
				return smstep_pkg::ST_OK;
			end
			smstep_pkg::OP_POP: begin
				if (depth == 0) return smstep_pkg::ST_UNDER;
				depth--;
				return smstep_pkg::ST_OK;
			end
			smstep_pkg::OP_COPY: begin
				if (depth >= STACK_DEPTH) return smstep_pkg::ST_OVER;
				if (64'(depth) < arg) return smstep_pkg::ST_UNDER;
				if (arg == 0) return smstep_pkg::ST_OVER;
				k = int'(arg[8:0]);
				data_mem[depth] = data_mem[depth-k];
				depth++;
				return smstep_pkg::ST_OK;
			end
			smstep_pkg::OP_SWAP: begin
				if (64'(depth) <= arg) return smstep_pkg::ST_UNDER;
				if (arg == 0) return smstep_pkg::ST_OVER;
				k = int'(arg[8:0]);
				t = data_mem[depth-1];
				data_mem[depth-1] = data_mem[depth-1-k];
				data_mem[depth-1-k] = t;
				return smstep_pkg::ST_OK;
			end
			smstep_pkg::OP_JMP: begin
				ip = arg;
				return smstep_pkg::ST_OK;
			end
			smstep_pkg::OP_JNZ: begin
				if (depth < 1) return smstep_pkg::ST_UNDER;
				if (data_mem[depth-1] != 0) ip = arg;
				depth--;
				return smstep_pkg::ST_OK;
			end
			smstep_pkg::OP_CALL: begin
				if (rdepth >= CALL_DEPTH) return smstep_pkg::ST_COVER;
				ret_mem[rdepth] = ip;
				rdepth++;
				ip = arg;
				return smstep_pkg::ST_OK;
			end
			smstep_pkg::OP_RET: begin
				if (rdepth < 1) return smstep_pkg::ST_CUNDER;
				ip = ret_mem[rdepth-1];
				rdepth--;
				return smstep_pkg::ST_OK;
			end
			default: begin
				if (o < smstep_pkg::OP_ADD_I || o > smstep_pkg::OP_LE_U)
					return smstep_pkg::ST_ILLEGAL;
				if (depth < 2) return smstep_pkg::ST_UNDER;
				a = data_mem[depth-2];
				b = data_mem[depth-1];
				case (o)
					smstep_pkg::OP_ADD_I, smstep_pkg::OP_ADD_U: r = a + b;
					smstep_pkg::OP_SUB_I, smstep_pkg::OP_SUB_U: r = a - b;
					smstep_pkg::OP_MUL_I, smstep_pkg::OP_MUL_U: r = a * b;
					smstep_pkg::OP_DIV_I: begin
						if (b == 0) return smstep_pkg::ST_DIVZERO;
						r = signed_quotient(a, b);
					end
					smstep_pkg::OP_DIV_U: begin
						if (b == 0) return smstep_pkg::ST_DIVZERO;
						r = a / b;
					end
					smstep_pkg::OP_EQ:   r = (a == b) ? 64'd1 : 64'd0;
					smstep_pkg::OP_NE:   r = (a != b) ? 64'd1 : 64'd0;
					smstep_pkg::OP_GT_I: r = ($signed(a) > $signed(b)) ? 64'd1 : 64'd0;
					smstep_pkg::OP_GE_I: r = ($signed(a) >= $signed(b)) ? 64'd1 : 64'd0;
					smstep_pkg::OP_LT_I: r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
					smstep_pkg::OP_LE_I: r = ($signed(a) <= $signed(b)) ? 64'd1 : 64'd0;
					smstep_pkg::OP_GT_U: r = (a > b) ? 64'd1 : 64'd0;
					smstep_pkg::OP_GE_U: r = (a >= b) ? 64'd1 : 64'd0;
					smstep_pkg::OP_LT_U: r = (a < b) ? 64'd1 : 64'd0;
					default: r = (a <= b) ? 64'd1 : 64'd0;
				endcase
				data_mem[depth-2] = r;
				depth--;
				return smstep_pkg::ST_OK;
			end
		endcase
	endfunction

	function automatic machine_view_t predict_item(logic c, logic [PA_W-1:0] a,
			logic [OP_W-1:0] o, logic [63:0] v);
		machine_view_t m;
		smstep_pkg::stat_t st;
		st = smstep_pkg::ST_OK;
		if (c == CMD_LOAD) begin
			prog_op[a]  = o;
			prog_arg[a] = v;
			written[a]  = 1'b1;
			n_loads++;
		end else begin
			st = execute_word();
			n_steps++;
			if (st != smstep_pkg::ST_OK) n_faults++;
		end
		m.status = st;
		m.halted = halt_flag;
		m.ip     = ip;
		m.count  = DEPTH_W'(depth);
		m.top    = (depth > 0) ? data_mem[depth-1] : 64'd0;
		m.calls  = CDEPTH_W'(rdepth);
		return m;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		err_count++;
	endtask

	task automatic check_result();
		machine_view_t w;
		if (pending_views.size() == 0) begin
			report_mismatch("result with nothing expected, ip", next_ip, 64'd0);
			return;
		end
		w = pending_views.pop_front();
		if (status != w.status)
			report_mismatch("status", 64'(status), 64'(w.status));
		if (halted != w.halted)
			report_mismatch("halted", 64'(halted), 64'(w.halted));
		if (next_ip != w.ip)
			report_mismatch("next_ip", next_ip, w.ip);
		if (stack_count != w.count)
			report_mismatch("stack_count", 64'(stack_count), 64'(w.count));
		if (top_value != w.top)
			report_mismatch("top_value", top_value, w.top);
		if (call_count != w.calls)
			report_mismatch("call_count", 64'(call_count), 64'(w.calls));
	endtask

	// result side: random stalls, a long hold-off when asked for, and no stalls in no-idle mode
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) check_result();
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic c, logic [PA_W-1:0] a, logic [OP_W-1:0] o,
			logic [63:0] v);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		load_address <= a;
		load_opcode  <= o;
		load_operand <= v;
		do @(posedge clk); while (!in_ready);
		pending_views.push_back(predict_item(c, a, o, v));
		@(negedge clk);
	endtask

	// write the word at ip if it lies inside the program length, then execute it
	task automatic run_word(logic [OP_W-1:0] o, logic [63:0] v);
		if (ip < 64'(fetch_limit()))
			send_item(CMD_LOAD, ip[PA_W-1:0], o, v);
		send_item(CMD_STEP, '0, '0, '0);
	endtask

	task automatic set_length(logic [PLEN_W-1:0] len);
		in_valid <= 1'b0;
		wait (pending_views.size() == 0);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
		plen = len;
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 6))
			0: return 64'd0;
			1: return 64'd1;
			2: return '1;
			3: return MIN_INT;
			4: return MAX_INT;
			5: return {$urandom, $urandom};
			default: return 64'($urandom_range(0, 9));
		endcase
	endfunction

	function automatic logic [63:0] pick_target(int lim);
		// now and then just past the end, so the next fetch faults
		if (lim + 2 < PROG_DEPTH && $urandom_range(0, 19) == 0)
			return 64'(lim + $urandom_range(0, 2));
		return 64'($urandom_range(0, lim - 1));
	endfunction

	function automatic logic [63:0] pick_offset();
		if ($urandom_range(0, 5) == 0) return {$urandom, $urandom};
		return 64'($urandom_range(0, depth + 1));
	endfunction

	task automatic make_word(output logic [OP_W-1:0] o, output logic [63:0] v);
		int p;
		int lim;
		p   = $urandom_range(0, 99);
		lim = fetch_limit();
		v   = '0;
		// the last word must jump, or ip would run off the store for good
		if (ip == 64'(PROG_DEPTH - 1)) begin
			o = smstep_pkg::OP_JMP;
			v = 64'($urandom_range(0, lim - 1));
		end else if (p < 22 && depth < 200) begin
			o = smstep_pkg::OP_PUSH;
			v = pick_value();
		end else if (p < 30) begin
			o = smstep_pkg::OP_POP;
		end else if (p < 36) begin
			o = smstep_pkg::OP_COPY;
			v = pick_offset();
		end else if (p < 42) begin
			o = smstep_pkg::OP_SWAP;
			v = pick_offset();
		end else if (p < 70) begin
			o = OP_W'($urandom_range(smstep_pkg::OP_ADD_I, smstep_pkg::OP_LE_U));
		end else if (p < 74) begin
			o = smstep_pkg::OP_NOP;
			v = {$urandom, $urandom};
		end else if (p < 76) begin
			o = smstep_pkg::OP_HALT;
		end else if (p < 82) begin
			o = smstep_pkg::OP_JMP;
			v = pick_target(lim);
		end else if (p < 88) begin
			o = smstep_pkg::OP_JNZ;
			v = pick_target(lim);
		end else if (p < 93) begin
			o = smstep_pkg::OP_CALL;
			v = pick_target(lim);
		end else if (p < 97) begin
			o = smstep_pkg::OP_RET;
		end else begin
			o = OP_W'($urandom_range(OP_BAD_LO, OP_BAD_HI));
			v = {$urandom, $urandom};
		end
	endtask

	task automatic test_empty_machine();
		logic [OP_W-1:0] o;
		set_length('0);
		send_item(CMD_STEP, '0, '0, '0);
		send_item(CMD_LOAD, '1, smstep_pkg::OP_PUSH, '1);
		send_item(CMD_STEP, '0, '0, '0);
		set_length(PLEN_W'(16));
		run_word(smstep_pkg::OP_POP, '0);
		run_word(smstep_pkg::OP_RET, '0);
		run_word(smstep_pkg::OP_JNZ, 64'd3);
		run_word(smstep_pkg::OP_COPY, 64'd1);
		run_word(smstep_pkg::OP_SWAP, '0);
		run_word(smstep_pkg::OP_NOP, '1);
		for (o = OP_BAD_LO; o != 5'd0; o++)
			run_word(o, '0);
		run_word(smstep_pkg::OP_HALT, '0);
		run_word(smstep_pkg::OP_JMP, '0);
	endtask

	task automatic test_operations();
		logic [OP_W-1:0] o;
		set_length(PLEN_W'(PROG_DEPTH));
		for (o = smstep_pkg::OP_ADD_I; o <= smstep_pkg::OP_LE_U; o++) begin
			run_word(smstep_pkg::OP_PUSH, pick_value());
			run_word(smstep_pkg::OP_PUSH, pick_value());
			run_word(o, '0);
			run_word(smstep_pkg::OP_PUSH, MIN_INT);
			run_word(smstep_pkg::OP_PUSH, (o == smstep_pkg::OP_DIV_U) ? 64'd0 : '1);
			run_word(o, '0);
			while (depth > 0) run_word(smstep_pkg::OP_POP, '0);
			run_word(smstep_pkg::OP_JMP, '0);
		end
		run_word(smstep_pkg::OP_PUSH, 64'd5);
		run_word(smstep_pkg::OP_PUSH, 64'd6);
		run_word(smstep_pkg::OP_PUSH, 64'd7);
		run_word(smstep_pkg::OP_COPY, 64'd3);
		run_word(smstep_pkg::OP_SWAP, 64'd2);
		run_word(smstep_pkg::OP_COPY, '0);
		run_word(smstep_pkg::OP_SWAP, 64'd4);
		run_word(smstep_pkg::OP_PUSH, 64'd1);
		run_word(smstep_pkg::OP_JNZ, 64'd40);
		run_word(smstep_pkg::OP_PUSH, 64'd0);
		run_word(smstep_pkg::OP_JNZ, 64'd2);
		run_word(smstep_pkg::OP_CALL, 64'd60);
		run_word(smstep_pkg::OP_RET, '0);
		while (depth > 0) run_word(smstep_pkg::OP_POP, '0);
		run_word(smstep_pkg::OP_JMP, '0);
	endtask

	task automatic test_stack_limits();
		logic [63:0] v;
		logic [63:0] here;
		// hold results back so the block fills up and stalls its input
		hold_cycles = 400;
		repeat (STACK_DEPTH + 1) begin
			v = pick_value();
			run_word(smstep_pkg::OP_PUSH, (v == '0) ? 64'd1 : v);
		end
		run_word(smstep_pkg::OP_COPY, 64'd1);
		run_word(smstep_pkg::OP_SWAP, 64'(STACK_DEPTH - 1));
		// a jnz on itself pops one nonzero entry per step
		here = ip;
		run_word(smstep_pkg::OP_JNZ, here);
		while (depth > 0) send_item(CMD_STEP, '0, '0, '0);
		send_item(CMD_STEP, '0, '0, '0);
		// a call on itself fills the return stack, a ret then drains it
		here = ip;
		run_word(smstep_pkg::OP_CALL, here);
		repeat (CALL_DEPTH) send_item(CMD_STEP, '0, '0, '0);
		run_word(smstep_pkg::OP_RET, '0);
		repeat (CALL_DEPTH) send_item(CMD_STEP, '0, '0, '0);
		run_word(smstep_pkg::OP_JMP, '0);
	endtask

	task automatic test_random_programs();
		logic [PLEN_W-1:0] lengths [8] = '{1, 7, 40, 300, 2047, 1024, 12, 600};
		logic [OP_W-1:0] o;
		logic [63:0] v;
		int n;
		foreach (lengths[p]) begin
			if (p == 7) no_idle = 1'b1;
			set_length(lengths[p]);
			if (ip >= 64'(fetch_limit())) run_word(smstep_pkg::OP_NOP, '0);
			if (ip < 64'(fetch_limit()))
				send_item(CMD_LOAD, ip[PA_W-1:0], smstep_pkg::OP_JMP, '0);
			for (n = 0; n < 30; n++) begin
				if ($urandom_range(0, 9) < 7) begin
					if (ip >= 64'(fetch_limit())) begin
						// stranded past the end: one faulting step, then widen
						send_item(CMD_STEP, '0, '0, '0);
						if (ip >= 64'(PROG_DEPTH)) return;
						set_length(PLEN_W'((ip + 1 + $urandom_range(0, 30) > PROG_DEPTH)
							? PROG_DEPTH : ip + 1 + $urandom_range(0, 30)));
					end else begin
						if (!written[ip[PA_W-1:0]] || ip == 64'(PROG_DEPTH - 1) ||
								$urandom_range(0, 1) == 0) begin
							make_word(o, v);
							send_item(CMD_LOAD, ip[PA_W-1:0], o, v);
						end
						send_item(CMD_STEP, '0, '0, '0);
					end
				end else begin
					send_item(CMD_LOAD, PA_W'($urandom), OP_W'($urandom), {$urandom, $urandom});
				end
			end
		end
	endtask

	task automatic test_wild_targets();
		set_length('1);
		run_word(smstep_pkg::OP_PUSH, MIN_INT);
		run_word(smstep_pkg::OP_JMP, '1);
		send_item(CMD_STEP, '0, '0, '0);
		send_item(CMD_STEP, '0, '0, '0);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		cmd          = CMD_LOAD;
		load_address = '0;
		load_opcode  = '0;
		load_operand = '0;
		err_count    = 0;
		cycles       = 0;
		hold_cycles  = 0;
		no_idle      = 1'b0;
		n_loads      = 0;
		n_steps      = 0;
		n_faults     = 0;
		depth        = 0;
		rdepth       = 0;
		ip           = '0;
		halt_flag    = 1'b0;
		plen         = '0;
		foreach (written[i]) written[i] = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_machine();
		test_operations();
		test_stack_limits();
		test_random_programs();
		test_wild_targets();

		in_valid <= 1'b0;
		wait (pending_views.size() == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d program loads and %0d steps, %0d of the steps faulting",
			n_loads, n_steps, n_faults);
		$display("stack limits, call depth limits and all opcodes exercised, %0d mismatches",
			err_count);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
